@@ hdl/lfc_pkg.sv @@
// ----------------------------------------------------------------------------
// lfc_pkg
// Shared types and field widths for the LRU frame cache.
// ----------------------------------------------------------------------------
package lfc_pkg;

  localparam int unsigned TagBits   = 16;
  localparam int unsigned IdxBits   = 9;
  localparam int unsigned EntryBits = 6;
  localparam int unsigned CfgBits   = 7;
  localparam int unsigned DataBits  = 64;

  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // lookup outcome handed from the tag directory to the data path
  typedef struct packed {
    logic                 hit;
    logic                 alloc;
    logic [EntryBits-1:0] entry;
  } lookup_t;

endpackage

@@ hdl/lru_frame_cache_top.sv @@
// ----------------------------------------------------------------------------
// lru_frame_cache_top
// Fully associative frame cache with exact LRU ranks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_* carries one access (read or write of one word of a
//   frame tagged by block and frame number). Result channel out_* returns
//   hit, the entry used and the read word for every access, in order.
//   cfg_we writes entries_in_use; write only while the block is idle.
// Timing:
//   After transfer an item passes tag search and rank update, data memory
//   access and registered read data before the result is valid. A new item
//   is taken no earlier than the cycle after the previous result transfers,
//   so the block does not take a new item before it is through with the last.
// Reset:
//   rst_n clears valid bits, sets ranks to the entry index and sets
//   entries_in_use to ENTRIES. Frame data is not cleared.
// Stall:
//   A held result stays on out_* and in_ready stays low until it transfers.
// ----------------------------------------------------------------------------
module lru_frame_cache_top #(
  parameter int unsigned ENTRIES     = 64,
  parameter int unsigned FRAME_WORDS = 512,
  parameter int unsigned WORD_BITS   = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [lfc_pkg::TagBits-1:0]       in_block_number,
  input  logic [lfc_pkg::TagBits-1:0]       in_frame_number,
  input  logic [lfc_pkg::IdxBits-1:0]       in_word_index,
  input  logic [lfc_pkg::DataBits-1:0]      in_write_word,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic [lfc_pkg::EntryBits-1:0]     out_entry_used,
  output logic [lfc_pkg::DataBits-1:0]      out_read_word,
  input  logic                              cfg_we,
  input  logic [lfc_pkg::CfgBits-1:0]       cfg_wdata
);

  localparam int unsigned EW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned WW    = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
  localparam int unsigned DEPTH = ENTRIES * FRAME_WORDS;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_MEM, ST_RD, ST_OUT} state_t;

  state_t                        state_r;
  logic [lfc_pkg::CfgBits-1:0]   eiu_r;
  logic                          op_r;
  logic [WW-1:0]                 widx_r;
  logic [WORD_BITS-1:0]          wdata_r;
  lfc_pkg::lookup_t              lk;
  logic [WORD_BITS-1:0]          rdata;
  logic                          in_xfer;
  logic [AW-1:0]                 addr;
  logic                          mem_en, mem_we;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) eiu_r <= lfc_pkg::CfgBits'(ENTRIES);
    else if (cfg_we) eiu_r <= cfg_wdata;
  end

  lfc_tag_dir #(.ENTRIES(ENTRIES)) u_dir (
    .clk(clk), .rst_n(rst_n), .lookup_en(in_xfer), .op(in_operation),
    .blk(in_block_number), .frm(in_frame_number), .entries_in_use(eiu_r),
    .result(lk)
  );

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r    <= in_operation;
      widx_r  <= WW'(in_word_index % FRAME_WORDS);
      wdata_r <= WORD_BITS'(in_write_word);
    end
  end

  assign addr   = AW'(lk.entry[EW-1:0] * FRAME_WORDS + widx_r);
  assign mem_en = (state_r == ST_MEM) && (lk.hit || lk.alloc);
  assign mem_we = mem_en && op_r == lfc_pkg::OpWrite;

  lfc_frame_mem #(.DEPTH(DEPTH), .WORD_BITS(WORD_BITS)) u_mem (
    .clk(clk), .en(mem_en), .we(mem_we), .addr(addr), .wdata(wdata_r),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: if (in_xfer) state_r <= ST_MEM;
        ST_MEM:  state_r <= ST_RD;
        ST_RD: begin
          out_valid      <= 1'b1;
          out_hit        <= lk.hit;
          out_entry_used <= lk.entry;
          // read word only on read hit
          out_read_word  <= (lk.hit && op_r == lfc_pkg::OpRead) ?
                            lfc_pkg::DataBits'(rdata) : '0;
          state_r        <= ST_OUT;
        end
        ST_OUT: if (out_ready) begin
          out_valid <= 1'b0;
          state_r   <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/lfc_tag_dir.sv @@
// ----------------------------------------------------------------------------
// lfc_tag_dir
// Tag directory: valid bits, tags and recency ranks per entry. Searches one
// tag per lookup, picks a victim on write miss and updates the ranks.
// ----------------------------------------------------------------------------
module lfc_tag_dir #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          lookup_en,
  input  logic                          op,
  input  logic [lfc_pkg::TagBits-1:0]   blk,
  input  logic [lfc_pkg::TagBits-1:0]   frm,
  input  logic [lfc_pkg::CfgBits-1:0]   entries_in_use,
  output lfc_pkg::lookup_t              result
);

  localparam int unsigned EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned NW = $clog2(ENTRIES + 1);
  localparam int unsigned LP = 1 << EW;

  logic [ENTRIES-1:0]               valid_r;
  logic [lfc_pkg::TagBits-1:0]      tag_blk_r [ENTRIES];
  logic [lfc_pkg::TagBits-1:0]      tag_frm_r [ENTRIES];
  logic [EW-1:0]                    rank_r    [ENTRIES];

  logic [NW-1:0]  n_act;
  logic [ENTRIES-1:0] in_use, match;
  logic           found, empty_found;
  logic [EW-1:0]  hit_e, empty_e, lru_e, sel_e;
  logic           touch;

  always_comb begin
    logic [lfc_pkg::CfgBits:0] c;
    c = {1'b0, entries_in_use};
    if (c == '0) c = (lfc_pkg::CfgBits+1)'(1);
    if (c > (lfc_pkg::CfgBits+1)'(ENTRIES)) c = (lfc_pkg::CfgBits+1)'(ENTRIES);
    n_act = NW'(c);
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      in_use[i] = (NW'(i) < n_act);
      match[i]  = in_use[i] && valid_r[i] && tag_blk_r[i] == blk && tag_frm_r[i] == frm;
    end
  end

  // priority encoders: lowest match, lowest empty
  always_comb begin
    found = 1'b0; hit_e = '0;
    empty_found = 1'b0; empty_e = '0;
    for (int i = ENTRIES-1; i >= 0; i--) begin
      if (match[i]) begin
        found = 1'b1; hit_e = EW'(i);
      end
      if (in_use[i] && !valid_r[i]) begin
        empty_found = 1'b1; empty_e = EW'(i);
      end
    end
  end

  // the oldest in-use entry carries the largest rank; reduce pairwise in a tree
  always_comb begin
    logic          nv [2*LP];
    logic [EW-1:0] ni [2*LP];
    logic [EW-1:0] nr [2*LP];
    for (int i = 0; i < 2*LP; i++) begin
      nv[i] = 1'b0; ni[i] = '0; nr[i] = '0;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      nv[LP+i] = in_use[i]; ni[LP+i] = EW'(i); nr[LP+i] = rank_r[i];
    end
    for (int k = LP-1; k >= 1; k--) begin
      if (nv[2*k+1] && (!nv[2*k] || nr[2*k+1] >= nr[2*k])) begin
        nv[k] = 1'b1; ni[k] = ni[2*k+1]; nr[k] = nr[2*k+1];
      end else begin
        nv[k] = nv[2*k]; ni[k] = ni[2*k]; nr[k] = nr[2*k];
      end
    end
    lru_e = ni[1];
  end

  always_comb begin
    sel_e = found ? hit_e : (empty_found ? empty_e : lru_e);
    touch = lookup_en && (found || op == lfc_pkg::OpWrite);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < ENTRIES; i++) rank_r[i] <= EW'(i);
    end else if (touch) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (rank_r[i] < rank_r[sel_e]) rank_r[i] <= rank_r[i] + 1'b1;
      end
      rank_r[sel_e] <= '0;
      if (!found) begin
        valid_r[sel_e]   <= 1'b1;
        tag_blk_r[sel_e] <= blk;
        tag_frm_r[sel_e] <= frm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_en) begin
      result.hit   <= found;
      result.alloc <= !found && op == lfc_pkg::OpWrite;
      result.entry <= lfc_pkg::EntryBits'(found || op == lfc_pkg::OpWrite ? sel_e : '0);
    end
  end

endmodule

@@ hdl/lfc_frame_mem.sv @@
// ----------------------------------------------------------------------------
// lfc_frame_mem
// Frame data store: one synchronous port, registered read data.
// ----------------------------------------------------------------------------
module lfc_frame_mem #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        we,
  input  logic [$clog2(DEPTH)-1:0]    addr,
  input  logic [WORD_BITS-1:0]        wdata,
  output logic [WORD_BITS-1:0]        rdata
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
    end
  end

endmodule

@@ hdl/lfc_checker.sv @@
// ----------------------------------------------------------------------------
// lfc_checker
// Port-level checks for the LRU frame cache.
// ----------------------------------------------------------------------------
module lfc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_hit,
  input logic [lfc_pkg::EntryBits-1:0] out_entry_used,
  input logic [lfc_pkg::DataBits-1:0]  out_read_word
);

  // no new transfer while a result is held
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  // a miss always carries zero data
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit && out_read_word != '0) |-> 1'b0)
    else $error("miss with nonzero data");

  // every transfer in is followed by a result once ST_MEM and ST_RD have passed
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##3 out_valid) else $error("result late");

  // result held, with entry used stable, while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_entry_used)))
    else $error("result dropped under stall");

endmodule

bind lru_frame_cache_top lfc_checker u_lfc_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_hit(out_hit),
  .out_entry_used(out_entry_used), .out_read_word(out_read_word)
);
